// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/lps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// shared types, constants and tables of the led pattern sequencer
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int PULSE_STEPS = 63;
   localparam int STEP_WIDTH  = 16;
   localparam int PULSE_IDX_W = $clog2(PULSE_STEPS);
   localparam int SOS_LEN     = 26;
   localparam int SOS_IDX_W   = 5;

   localparam logic [15:0] PER_PULSE = 16'd20;
   localparam logic [15:0] PER_SOS   = 16'd200;
   localparam logic [15:0] PER_DUAL  = 16'd250;

   localparam logic [SOS_LEN-1:0] SOS_BITS = 26'b00_0010_1010_0110_1101_1001_0101;

   typedef enum logic [3:0] {
      PAT_OFF     = 4'd0,
      PAT_ON      = 4'd1,
      PAT_SLOW    = 4'd2,
      PAT_FAST    = 4'd3,
      PAT_VFAST   = 4'd4,
      PAT_PULSE   = 4'd5,
      PAT_HEART   = 4'd6,
      PAT_SOS     = 4'd7,
      PAT_STARTUP = 4'd8,
      PAT_DUAL    = 4'd9
   } pattern_type;

   typedef enum logic [2:0] {
      REG_PATTERN   = 3'd0,
      REG_PRIMARY   = 3'd1,
      REG_SECONDARY = 3'd2,
      REG_ENABLE    = 3'd3,
      REG_RGB       = 3'd4,
      REG_SLOW      = 3'd5,
      REG_FAST      = 3'd6,
      REG_VFAST     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  pattern;
      logic [23:0] primary;
      logic [23:0] secondary;
      logic        enabled;
      logic        rgb_present;
      logic [15:0] slow_period;
      logic [15:0] fast_period;
      logic [15:0] vfast_period;
   } cfg_type;

   typedef struct packed {
      logic       rgb_written;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       user_written;
      logic       user_led_on;
   } rsp_type;

   function automatic logic sos_lit(input logic [SOS_IDX_W-1:0] idx);
      logic lit;
      lit = 1'b0;
      if (idx < SOS_IDX_W'(SOS_LEN)) begin
         lit = SOS_BITS[idx];
      end
      return lit;
   endfunction

   // floor((sin(k/10)+1)*127.5)
   function automatic logic [7:0] pulse_level(input logic [5:0] k);
      logic [7:0] b;
      case (k)
         6'd0:  b = 8'd127;  6'd1:  b = 8'd140;  6'd2:  b = 8'd152;  6'd3:  b = 8'd165;
         6'd4:  b = 8'd177;  6'd5:  b = 8'd188;  6'd6:  b = 8'd199;  6'd7:  b = 8'd209;
         6'd8:  b = 8'd218;  6'd9:  b = 8'd227;  6'd10: b = 8'd234;  6'd11: b = 8'd241;
         6'd12: b = 8'd246;  6'd13: b = 8'd250;  6'd14: b = 8'd253;  6'd15: b = 8'd254;
         6'd16: b = 8'd254;  6'd17: b = 8'd253;  6'd18: b = 8'd251;  6'd19: b = 8'd248;
         6'd20: b = 8'd243;  6'd21: b = 8'd237;  6'd22: b = 8'd230;  6'd23: b = 8'd222;
         6'd24: b = 8'd213;  6'd25: b = 8'd203;  6'd26: b = 8'd193;  6'd27: b = 8'd181;
         6'd28: b = 8'd170;  6'd29: b = 8'd158;  6'd30: b = 8'd145;  6'd31: b = 8'd132;
         6'd32: b = 8'd120;  6'd33: b = 8'd107;  6'd34: b = 8'd94;   6'd35: b = 8'd82;
         6'd36: b = 8'd71;   6'd37: b = 8'd59;   6'd38: b = 8'd49;   6'd39: b = 8'd39;
         6'd40: b = 8'd31;   6'd41: b = 8'd23;   6'd42: b = 8'd16;   6'd43: b = 8'd10;
         6'd44: b = 8'd6;    6'd45: b = 8'd2;    6'd46: b = 8'd0;    6'd47: b = 8'd0;
         6'd48: b = 8'd0;    6'd49: b = 8'd2;    6'd50: b = 8'd5;    6'd51: b = 8'd9;
         6'd52: b = 8'd14;   6'd53: b = 8'd21;   6'd54: b = 8'd28;   6'd55: b = 8'd37;
         6'd56: b = 8'd47;   6'd57: b = 8'd57;   6'd58: b = 8'd68;   6'd59: b = 8'd79;
         6'd60: b = 8'd91;   6'd61: b = 8'd104;  6'd62: b = 8'd116;  6'd63: b = 8'd129;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/lps_dimmer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_dimmer
// scales each channel of a colour by a brightness, c*b/255 rounded down
// ----------------------------------------------------------------------------
module lps_dimmer (
   input  logic [23:0] colour,
   input  logic [7:0]  level,
   output logic [23:0] dimmed
);
   import lps_pkg::*;

   logic [15:0] prod [3];
   logic [16:0] corr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i] = 16'(colour[8*i +: 8]) * 16'(level);
         // exact floor(x/255) for x up to 255*255
         corr[i] = {1'b0, prod[i]} + 17'd1 + 17'(prod[i][15:8]);
         dimmed[8*i +: 8] = corr[i][15:8];
      end
   end

endmodule

// ----- rtl/core/lps_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_engine
// pattern state registers and the per-tick next-state and result logic
// ----------------------------------------------------------------------------
module lps_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            clear,
   input  logic [7:0]      ms_passed,
   input  lps_pkg::cfg_type cfg,
   output logic            emit,
   output lps_pkg::rsp_type result
);
   import lps_pkg::*;

   logic [15:0]            elapsed_ff;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [SOS_IDX_W-1:0]   sos_ff;
   logic [PULSE_IDX_W-1:0] pulse_ff;
   logic                   done_ff;

   logic [16:0] elapsed_sum;
   logic [15:0] elapsed_in;
   logic [3:0]  code;
   logic        hit;
   logic        advance;
   logic        done_set;
   logic [23:0] user_col;
   logic [23:0] rgb_col;
   logic [23:0] dim_primary;
   logic [23:0] dim_secondary;
   logic [7:0]  level;
   logic [15:0] period;
   logic        heart_lit;
   logic [9:0]  user_sum;

   assign elapsed_sum = {1'b0, elapsed_ff} + 17'(ms_passed);
   assign elapsed_in  = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
   assign code        = done_ff ? PAT_OFF : cfg.pattern;
   assign level       = pulse_level(6'(pulse_ff));
   assign heart_lit   = (step_ff[2:0] == 3'd0) || (step_ff[2:0] == 3'd2);

   lps_dimmer u_dim_primary (
      .colour (cfg.primary),
      .level  (level),
      .dimmed (dim_primary)
   );

   lps_dimmer u_dim_secondary (
      .colour (cfg.secondary),
      .level  (level),
      .dimmed (dim_secondary)
   );

   always_comb begin
      hit      = 1'b0;
      advance  = 1'b0;
      done_set = 1'b0;
      user_col = '0;
      rgb_col  = '0;
      period   = cfg.slow_period;
      case (code)
         PAT_OFF: begin
            hit = 1'b1;
         end
         PAT_ON: begin
            hit      = 1'b1;
            user_col = cfg.primary;
            rgb_col  = cfg.secondary;
         end
         PAT_PULSE: begin
            advance  = elapsed_in > PER_PULSE;
            user_col = dim_primary;
            rgb_col  = dim_secondary;
         end
         PAT_HEART: begin
            advance  = elapsed_in > cfg.fast_period;
            user_col = heart_lit ? cfg.primary : 24'd0;
            rgb_col  = heart_lit ? cfg.secondary : 24'd0;
         end
         PAT_SOS: begin
            advance  = elapsed_in > PER_SOS;
            user_col = sos_lit(sos_ff) ? cfg.primary : 24'd0;
            rgb_col  = sos_lit(sos_ff) ? cfg.secondary : 24'd0;
         end
         PAT_STARTUP: begin
            advance = elapsed_in > cfg.fast_period;
            if (step_ff < STEP_WIDTH'(10)) begin
               user_col = step_ff[0] ? 24'd0 : cfg.primary;
               rgb_col  = step_ff[0] ? cfg.secondary : 24'd0;
            end else if (step_ff < STEP_WIDTH'(15)) begin
               user_col = cfg.primary;
               rgb_col  = cfg.secondary;
            end else begin
               done_set = advance;
            end
         end
         PAT_DUAL: begin
            advance  = elapsed_in > PER_DUAL;
            user_col = step_ff[1] ? 24'd0 : cfg.primary;
            rgb_col  = step_ff[1] ? cfg.secondary : 24'd0;
         end
         default: begin
            if (code == PAT_FAST) begin
               period = cfg.fast_period;
            end else if (code == PAT_VFAST) begin
               period = cfg.vfast_period;
            end
            advance  = elapsed_in > period;
            user_col = step_ff[0] ? 24'd0 : cfg.primary;
            rgb_col  = step_ff[0] ? 24'd0 : cfg.secondary;
         end
      endcase
   end

   assign user_sum = 10'(user_col[23:16]) + 10'(user_col[15:8]) + 10'(user_col[7:0]);
   assign emit     = cfg.enabled && (hit || advance);

   always_comb begin
      result.user_led_on  = user_sum >= 10'd3;
      result.user_written = 1'b1;
      result.rgb_written  = cfg.rgb_present;
      result.red          = cfg.rgb_present ? rgb_col[23:16] : 8'd0;
      result.green        = cfg.rgb_present ? rgb_col[15:8] : 8'd0;
      result.blue         = cfg.rgb_present ? rgb_col[7:0] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         elapsed_ff <= '0;
         step_ff    <= '0;
         sos_ff     <= '0;
         pulse_ff   <= '0;
         done_ff    <= 1'b0;
      end else if (fire) begin
         if (cfg.enabled && advance) begin
            elapsed_ff <= '0;
            step_ff    <= step_ff + STEP_WIDTH'(1);
            sos_ff     <= (sos_ff == SOS_IDX_W'(SOS_LEN - 1)) ? '0 : sos_ff + SOS_IDX_W'(1);
            pulse_ff   <= (pulse_ff == PULSE_IDX_W'(PULSE_STEPS - 1)) ? '0
                          : pulse_ff + PULSE_IDX_W'(1);
            if (done_set) begin
               done_ff <= 1'b1;
            end
         end else begin
            elapsed_ff <= elapsed_in;
         end
      end
   end

endmodule

// ----- rtl/core/led_pattern_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// tick-driven led pattern sequencer with user and rgb led results
// ----------------------------------------------------------------------------
// an input transfer passes the input register, then the result register, before its result transfer
// throughput: one tick per cycle while the result channel is not stalled, set by the input and result registers
// a tick that yields no result still takes one pass through the engine
// reset: synchronous, active high; config registers return to their defaults,
// pattern state clears and both channels empty
module led_pattern_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ms_passed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // user_led_on, user_written, rgb_red, rgb_green, rgb_blue, rgb_written
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import lps_pkg::*;

`include "assert_macros.svh"

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_ms_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       fire;
   logic       clear;
   logic       emit;
   rsp_type    result;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign clear      = csr_we && (csr_index == REG_PATTERN);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern      <= PAT_OFF;
         cfg_ff.primary      <= 24'hFFFFFF;
         cfg_ff.secondary    <= 24'h0000FF;
         cfg_ff.enabled      <= 1'b1;
         cfg_ff.rgb_present  <= 1'b0;
         cfg_ff.slow_period  <= 16'd1000;
         cfg_ff.fast_period  <= 16'd500;
         cfg_ff.vfast_period <= 16'd100;
      end else if (csr_we) begin
         case (csr_index)
            REG_PATTERN:   cfg_ff.pattern      <= csr_wdata[3:0];
            REG_PRIMARY:   cfg_ff.primary      <= csr_wdata;
            REG_SECONDARY: cfg_ff.secondary    <= csr_wdata;
            REG_ENABLE:    cfg_ff.enabled      <= csr_wdata[0];
            REG_RGB:       cfg_ff.rgb_present  <= csr_wdata[0];
            REG_SLOW:      cfg_ff.slow_period  <= csr_wdata[15:0];
            REG_FAST:      cfg_ff.fast_period  <= csr_wdata[15:0];
            REG_VFAST:     cfg_ff.vfast_period <= csr_wdata[15:0];
            default:       cfg_ff.pattern      <= cfg_ff.pattern;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ms_ff <= req_tdata;
      end
   end

   lps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .clear     (clear),
      .ms_passed (in_ms_ff),
      .cfg       (cfg_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_ff <= result;
      end
   end

   `ASSERT_IMPLY(a_user_written, clock, reset, rsp_valid_ff, rsp_ff.user_written)
   `ASSERT_IMPLY(a_rgb_quiet, clock, reset, rsp_valid_ff && !rsp_ff.rgb_written, rsp_tdata[25:2] == 24'd0)
   `ASSERT_IMPLY(a_empty_ready, clock, reset, !in_valid_ff, req_tready)
   `ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_tready, in_valid_ff)

endmodule
